/* rtl/three_layer_argb_compositor_macros.svh */
// assertion macros used by the compositor checker
`ifndef THREE_LAYER_ARGB_COMPOSITOR_MACROS_SVH
`define THREE_LAYER_ARGB_COMPOSITOR_MACROS_SVH

// same-cycle implication, checked on every rising clock outside reset
`define TLAC_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked on every rising clock outside reset
`define TLAC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/tlac_pkg.sv */
// ----------------------------------------------------------------------------
// tlac_pkg
// Types, constants and blend arithmetic for the three-layer ARGB compositor.
// ----------------------------------------------------------------------------
`default_nettype none

package tlac_pkg;

   localparam logic [7:0]  CHAN_MAX     = 8'hFF;
   localparam logic [7:0]  OPAQUE_ALPHA = 8'hFF;
   localparam int          ALPHA_SHIFT  = 24;

   // one input item: three layers of one pixel position
   typedef struct packed {
      logic [31:0] back_pixel;
      logic [31:0] fore_pixel;
      logic [31:0] pointer_pixel;
      logic        run_end_in;
   } req_payload_type;

   // one result item
   typedef struct packed {
      logic [31:0] out_pixel;
      logic        run_end_out;
   } rsp_payload_type;

   // per-channel weighted sums before the divide by 255
   typedef struct packed {
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
   } blend_sums_type;

   // s*a + d*(255-a), at most 65025 so it fits 16 bits
   function automatic logic [15:0] mix_sum(input logic [7:0] s, input logic [7:0] d,
                                           input logic [7:0] a);
      logic [15:0] top_part;
      logic [15:0] low_part;
      top_part = {8'h00, s} * {8'h00, a};
      low_part = {8'h00, d} * {8'h00, CHAN_MAX - a};
      return top_part + low_part;
   endfunction

   // exact x / 255 for x up to 65279: (x + 1 + (x >> 8)) >> 8
   function automatic logic [7:0] div_255(input logic [15:0] x);
      logic [16:0] t;
      t = {1'b0, x} + 17'd1 + {9'b0, x[15:8]};
      return t[15:8];
   endfunction

   // weighted sums of top blended over below, alpha from the top pixel
   function automatic blend_sums_type blend_sums(input logic [31:0] top,
                                                 input logic [31:0] below);
      blend_sums_type sums;
      logic [7:0]     a;
      a      = top[ALPHA_SHIFT +: 8];
      sums.r = mix_sum(top[23:16], below[23:16], a);
      sums.g = mix_sum(top[15:8], below[15:8], a);
      sums.b = mix_sum(top[7:0], below[7:0], a);
      return sums;
   endfunction

   // opaque pixel from the weighted sums
   function automatic logic [31:0] blend_finish(input blend_sums_type sums);
      return {OPAQUE_ALPHA, div_255(sums.r), div_255(sums.g), div_255(sums.b)};
   endfunction

endpackage

`default_nettype wire

/* rtl/three_layer_argb_compositor.sv */
// Three-layer ARGB8888 compositor: each item carries a background, foreground
// and cursor pixel; the foreground is blended over the background when its
// alpha is nonzero, then the cursor over that when its alpha is nonzero, each
// channel as (s*a + d*(255-a))/255 truncated, alpha forced to 255 once any
// blend applies. One pixel per clock is accepted and delivered while rsp_ready
// is high; a result reaches rsp_valid through the four register stages
// (foreground products, foreground divide, cursor products, cursor divide into
// the output register), the first of which loads at the accepting edge. Each
// stage has its own valid bit and its own load enable, so a stall at rsp_ready
// fills bubbles before holding the input.
`default_nettype none

// ----------------------------------------------------------------------------
// three_layer_argb_compositor
// Four-stage pipelined source-over blend of foreground and cursor layers.
// ----------------------------------------------------------------------------
module three_layer_argb_compositor (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  tlac_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output tlac_pkg::rsp_payload_type rsp_data
);

   // stage valid bits
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, out_valid_ff;
   // stage load enables
   logic s1_en, s2_en, s3_en, out_en;

   // stage 1: foreground products
   logic [31:0]              s1_back_ff, s1_ptr_ff;
   logic                     s1_end_ff, s1_fore_use_ff;
   tlac_pkg::blend_sums_type s1_sum_ff, s1_sum_in;

   // stage 2: foreground result
   logic [31:0] s2_pix_ff, s2_pix_in, s2_ptr_ff;
   logic        s2_end_ff;

   // stage 3: cursor products
   logic [31:0]              s3_pix_ff;
   logic                     s3_end_ff, s3_ptr_use_ff;
   tlac_pkg::blend_sums_type s3_sum_ff, s3_sum_in;

   // output register
   tlac_pkg::rsp_payload_type out_ff, out_in;

   // a stage loads when it is empty or its successor loads
   assign out_en    = !out_valid_ff || rsp_ready;
   assign s3_en     = !s3_valid_ff || out_en;
   assign s2_en     = !s2_valid_ff || s3_en;
   assign s1_en     = !s1_valid_ff || s2_en;
   assign req_ready = s1_en;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // datapath next values
   always_comb begin
      s1_sum_in          = tlac_pkg::blend_sums(req_data.fore_pixel, req_data.back_pixel);
      s2_pix_in          = s1_fore_use_ff ? tlac_pkg::blend_finish(s1_sum_ff) : s1_back_ff;
      s3_sum_in          = tlac_pkg::blend_sums(s2_ptr_ff, s2_pix_ff);
      out_in.out_pixel   = s3_ptr_use_ff ? tlac_pkg::blend_finish(s3_sum_ff) : s3_pix_ff;
      out_in.run_end_out = s3_end_ff;
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_en) s1_valid_ff <= req_valid;
         if (s2_en) s2_valid_ff <= s1_valid_ff;
         if (s3_en) s3_valid_ff <= s2_valid_ff;
         if (out_en) out_valid_ff <= s3_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_back_ff     <= req_data.back_pixel;
         s1_ptr_ff      <= req_data.pointer_pixel;
         s1_end_ff      <= req_data.run_end_in;
         s1_fore_use_ff <= (req_data.fore_pixel[tlac_pkg::ALPHA_SHIFT +: 8] != 8'h00);
         s1_sum_ff      <= s1_sum_in;
      end
      if (s2_en) begin
         s2_pix_ff <= s2_pix_in;
         s2_ptr_ff <= s1_ptr_ff;
         s2_end_ff <= s1_end_ff;
      end
      if (s3_en) begin
         s3_pix_ff     <= s2_pix_ff;
         s3_end_ff     <= s2_end_ff;
         s3_ptr_use_ff <= (s2_ptr_ff[tlac_pkg::ALPHA_SHIFT +: 8] != 8'h00);
         s3_sum_ff     <= s3_sum_in;
      end
      if (out_en) begin
         out_ff <= out_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/tlac_checker.sv */
// ----------------------------------------------------------------------------
// tlac_checker
// Port-level checks of the compositor pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "three_layer_argb_compositor_macros.svh"

module tlac_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_valid,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input tlac_pkg::rsp_payload_type rsp_data
);

   localparam logic [2:0] PIPE_DEPTH = 3'd4;

   // items accepted but not yet delivered
   logic [2:0] pending_ff, pending_in;
   logic       take_req, take_rsp;

   assign take_req = req_valid && req_ready;
   assign take_rsp = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (take_req && !take_rsp) pending_in = pending_ff + 3'd1;
      if (!take_req && take_rsp) pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 3'd0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled item holds
   `TLAC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")
   // no item appears that was never accepted
   `TLAC_ASSERT_NOW(a_no_invented, clock, reset, rsp_valid, pending_ff != 3'd0, "rsp item without accepted item")
   // the pipeline never holds more items than it has stages
   `TLAC_ASSERT_NOW(a_depth, clock, reset, 1'b1, pending_ff <= PIPE_DEPTH, "more items in flight than stages")
   // an empty output register means every stage can move
   `TLAC_ASSERT_NOW(a_ready_free, clock, reset, !rsp_valid, req_ready, "input stalled with output empty")

endmodule

bind three_layer_argb_compositor tlac_checker u_tlac_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

/* tb/tb_three_layer_argb_compositor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_three_layer_argb_compositor
// Self-checking bench for the three-layer ARGB compositor. Pixels go in over
// the req channel and come back over the rsp channel. Every accepted pixel is
// composited by a local source-over model and queued. Each returned pixel is
// compared with the oldest queued one. Both channels idle and stall at random,
// phase by phase.
// ----------------------------------------------------------------------------
module tb_three_layer_argb_compositor;

   localparam int CLK_HIGH_NS   = 4;
   localparam int CLK_LOW_NS    = 4;
   localparam int RESET_CYCLES  = 12;
   localparam int TAIL_CYCLES   = 16;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int CHUNK_ITEMS   = 155;
   localparam int PHASE_COUNT   = 4;
   localparam int ROUND_COUNT   = 2;
   localparam int CHAN_FULL     = 255;

   // composites accepted pixels and checks returned ones in order
   class composite_checker;
      tlac_pkg::rsp_payload_type expected_pixels[$];
      int                        mismatch_count;
      int                        result_index;

      function new();
         mismatch_count = 0;
         result_index   = 0;
      endfunction

      // source-over of one layer, alpha from the top layer, result opaque
      function logic [31:0] blend_layer(input logic [31:0] top,
                                        input logic [31:0] below);
         int unsigned  alpha;
         int unsigned  src;
         int unsigned  dst;
         logic [31:0]  pix;
         alpha = top[tlac_pkg::ALPHA_SHIFT +: 8];
         pix   = '0;
         pix[tlac_pkg::ALPHA_SHIFT +: 8] = tlac_pkg::OPAQUE_ALPHA;
         for (int sh = 0; sh < tlac_pkg::ALPHA_SHIFT; sh += 8) begin
            src = top[sh +: 8];
            dst = below[sh +: 8];
            pix[sh +: 8] = 8'((src * alpha + dst * (CHAN_FULL - alpha)) / CHAN_FULL);
         end
         return pix;
      endfunction

      function tlac_pkg::rsp_payload_type composite_pixel(
         input tlac_pkg::req_payload_type item);
         tlac_pkg::rsp_payload_type res;
         logic [31:0]               pix;
         pix = item.back_pixel;
         if (item.fore_pixel[tlac_pkg::ALPHA_SHIFT +: 8] != 8'h00)
            pix = blend_layer(item.fore_pixel, pix);
         if (item.pointer_pixel[tlac_pkg::ALPHA_SHIFT +: 8] != 8'h00)
            pix = blend_layer(item.pointer_pixel, pix);
         res.out_pixel   = pix;
         res.run_end_out = item.run_end_in;
         return res;
      endfunction

      function void note_pixel(input tlac_pkg::req_payload_type item);
         expected_pixels.push_back(composite_pixel(item));
      endfunction

      function int pending();
         return expected_pixels.size();
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         $display("mismatch at item %0d, %0s: got %h want %h", result_index, what, got, want);
         mismatch_count++;
      endtask

      task check_pixel(input tlac_pkg::rsp_payload_type got);
         tlac_pkg::rsp_payload_type want;
         if (expected_pixels.size() == 0) begin
            report_mismatch("item with none pending", got.out_pixel, '0);
         end else begin
            want = expected_pixels.pop_front();
            if (got.out_pixel !== want.out_pixel)
               report_mismatch("out_pixel", got.out_pixel, want.out_pixel);
            if (got.run_end_out !== want.run_end_out)
               report_mismatch("run_end_out", 32'(got.run_end_out), 32'(want.run_end_out));
         end
         result_index++;
      endtask
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   tlac_pkg::req_payload_type req_data = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   tlac_pkg::rsp_payload_type rsp_data;

   int              send_idle_pct  = 0;
   int              recv_stall_pct = 0;
   int              cycle_count    = 0;
   int              phase_send_pct[PHASE_COUNT] = '{0, 78, 0, 18};
   int              phase_recv_pct[PHASE_COUNT] = '{0, 0, 78, 18};

   composite_checker scoreboard = new();

   three_layer_argb_compositor u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // clock
   always begin
      #CLK_HIGH_NS clock = 1'b1;
      #CLK_LOW_NS  clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // result side: check accepted items, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         scoreboard.check_pixel(rsp_data);
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // present one pixel, with a random gap first, and wait for acceptance
   task automatic send_pixel(input tlac_pkg::req_payload_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      scoreboard.note_pixel(item);
   endtask

   task automatic send_layers(input logic [31:0] back, input logic [31:0] fore,
                              input logic [31:0] pointer, input logic run_end);
      tlac_pkg::req_payload_type item;
      item.back_pixel    = back;
      item.fore_pixel    = fore;
      item.pointer_pixel = pointer;
      item.run_end_in    = run_end;
      send_pixel(item);
   endtask

   // hold off the sender until every pixel has come back
   task automatic drain_pixels();
      req_valid <= 1'b0;
      while (scoreboard.pending() != 0) @(posedge clock);
   endtask

   // layer pixel with alpha biased toward zero, full and near the ends
   function automatic logic [31:0] random_layer();
      logic [7:0] alpha;
      int         pick;
      pick = $urandom_range(99);
      if (pick < 25)      alpha = 8'h00;
      else if (pick < 40) alpha = 8'hFF;
      else if (pick < 45) alpha = 8'h01;
      else if (pick < 50) alpha = 8'hFE;
      else                alpha = 8'($urandom);
      return {alpha, 24'($urandom)};
   endfunction

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes and the special cases
      send_layers(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0);
      send_layers(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      // no upper layer: background alpha kept, even zero or partial
      send_layers(32'h0012_3456, 32'h00FF_FFFF, 32'h00AB_CDEF, 1'b0);
      send_layers(32'h7F80_4020, 32'h0011_2233, 32'h0044_5566, 1'b1);
      // full alpha replaces the color below
      send_layers(32'h40FF_8001, 32'hFF12_3456, 32'h0000_0000, 1'b0);
      send_layers(32'h40FF_8001, 32'h0012_3456, 32'hFF65_4321, 1'b0);
      send_layers(32'h0000_0000, 32'hFF00_FF00, 32'hFFFF_00FF, 1'b0);
      // lowest and highest partial alpha
      send_layers(32'h00FF_FFFF, 32'h0100_0000, 32'h0000_0000, 1'b0);
      send_layers(32'hFF00_0000, 32'h0000_0000, 32'h01FF_FFFF, 1'b1);
      send_layers(32'h0000_0000, 32'hFEFF_FFFF, 32'h0000_0000, 1'b0);
      send_layers(32'hFFFF_FFFF, 32'h0000_0000, 32'hFE00_0000, 1'b0);
      // half alpha over opposite extremes, both layers partial
      send_layers(32'h0000_0000, 32'h80FF_FFFF, 32'h0000_0000, 1'b0);
      send_layers(32'h00FF_FFFF, 32'h8000_0000, 32'h80FF_FFFF, 1'b1);
      send_layers(32'h1234_5678, 32'h9ABC_DEF0, 32'h5A5A_A5A5, 1'b0);
      // upper-layer alpha of 0x80, 0x01 and 0x7F, colors alternating
      send_layers(32'hAAAA_AAAA, 32'h8055_5555, 32'h0155_AA55, 1'b1);
      send_layers(32'h5555_5555, 32'h01AA_AAAA, 32'h7FAA_55AA, 1'b0);
      drain_pixels();

      // random: each round walks through the idling phases
      for (int round = 0; round < ROUND_COUNT; round++) begin
         for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            send_idle_pct  = phase_send_pct[ph];
            recv_stall_pct = phase_recv_pct[ph];
            for (int n = 0; n < CHUNK_ITEMS; n++)
               send_layers(32'($urandom), random_layer(), random_layer(),
                           ($urandom_range(7) == 0));
            drain_pixels();
         end
      end

      // let any stray item show up before the verdict
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (TAIL_CYCLES) @(posedge clock);
      if (scoreboard.mismatch_count == 0 && scoreboard.pending() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

/* sim.f */
+incdir+rtl
rtl/tlac_pkg.sv
rtl/three_layer_argb_compositor.sv
rtl/tlac_checker.sv
tb/tb_three_layer_argb_compositor.sv
